// ===== rtl/core/rrt_pkg.sv =====
// Shared types, constants and codes of the route table lookup block.
package rrt_pkg;

    // Default sizes of the table and of the router.
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_MAX_OPTIONS   = 4;
    localparam int DEF_PORT_COUNT    = 32;

    // Fixed field widths.
    localparam int ADDR_W   = 8;
    localparam int OCNT_W   = 3;
    localparam int PORT_W   = 5;
    localparam int MASK_W   = 32;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 7;
    localparam int IN_OPT_N = 4;

    // Command codes of an input word.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    typedef enum logic [1:0] {
        DEC_GRANT   = 2'd0,
        DEC_WAIT    = 2'd1,
        DEC_DISCARD = 2'd2,
        DEC_WRITTEN = 2'd3
    } t_decision;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic in_write;
        logic has_more;
        logic eval_valid;
        logic eval_grant;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/rrt_req_if.sv =====
// Request channel: table writes and route requests.
interface rrt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [rrt_pkg::IDX_W-1:0]      entry_index;
    logic [rrt_pkg::ADDR_W-1:0]     target_address;
    logic [rrt_pkg::OCNT_W-1:0]     option_count;
    logic [rrt_pkg::PORT_W-1:0]     option_port_0;
    logic [rrt_pkg::PORT_W-1:0]     option_port_1;
    logic [rrt_pkg::PORT_W-1:0]     option_port_2;
    logic [rrt_pkg::PORT_W-1:0]     option_port_3;
    logic [rrt_pkg::PORT_W-1:0]     source_port;
    logic [rrt_pkg::MASK_W-1:0]     available_mask;

    modport source (
        output valid, command, entry_index, target_address, option_count,
               option_port_0, option_port_1, option_port_2, option_port_3,
               source_port, available_mask,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, target_address, option_count,
               option_port_0, option_port_1, option_port_2, option_port_3,
               source_port, available_mask,
        output ready
    );
endinterface

// ===== rtl/core/rrt_rsp_if.sv =====
// Response channel: routing decisions and write acknowledgements.
interface rrt_rsp_if;
    logic                       valid;
    logic                       ready;
    rrt_pkg::t_decision         decision;
    logic [rrt_pkg::PORT_W-1:0] granted_port;
    logic [rrt_pkg::MASK_W-1:0] requester_mask;

    modport source (
        output valid, decision, granted_port, requester_mask,
        input  ready
    );

    modport sink (
        input  valid, decision, granted_port, requester_mask,
        output ready
    );
endinterface

// ===== rtl/core/rrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/core/rrt_ctrl.sv =====
// Controller state machine of the route table lookup.
module rrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rrt_pkg::t_dp_status i_status,
    output rrt_pkg::t_dp_cmd    o_cmd
);
    import rrt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // A write needs no scan; its acknowledgement is ready at once.
                if (i_in_valid) begin
                    n_state = i_status.in_write ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.eval_grant || (!i_status.has_more && !i_status.eval_valid)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.finish = i_status.eval_grant
                             || (!i_status.has_more && !i_status.eval_valid);
                o_cmd.issue  = i_status.has_more && !i_status.eval_grant;
            end
            ST_DONE: begin
                o_cmd.push = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end
endmodule

// ===== rtl/core/rrt_datapath.sv =====
// Datapath of the route table lookup: table RAM, scan counter and result registers.
module rrt_datapath #(
    parameter int TABLE_ENTRIES = rrt_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_OPTIONS   = rrt_pkg::DEF_MAX_OPTIONS,
    parameter int PORT_COUNT    = rrt_pkg::DEF_PORT_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rrt_pkg::t_dp_cmd            i_cmd,
    output rrt_pkg::t_dp_status         o_status,
    input  logic                        i_command,
    input  logic [rrt_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [rrt_pkg::ADDR_W-1:0]  i_target_address,
    input  logic [rrt_pkg::OCNT_W-1:0]  i_option_count,
    input  logic [rrt_pkg::PORT_W-1:0]  i_option_port_0,
    input  logic [rrt_pkg::PORT_W-1:0]  i_option_port_1,
    input  logic [rrt_pkg::PORT_W-1:0]  i_option_port_2,
    input  logic [rrt_pkg::PORT_W-1:0]  i_option_port_3,
    input  logic [rrt_pkg::PORT_W-1:0]  i_source_port,
    input  logic [rrt_pkg::MASK_W-1:0]  i_available_mask,
    input  logic                        i_cfg_wr_en,
    input  logic [rrt_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output rrt_pkg::t_decision          o_decision,
    output logic [rrt_pkg::PORT_W-1:0]  o_granted_port,
    output logic [rrt_pkg::MASK_W-1:0]  o_requester_mask
);
    import rrt_pkg::*;

    localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int OPT_W    = PORT_W * MAX_OPTIONS;
    localparam int ROW_W    = ADDR_W + OCNT_W + OPT_W;
    localparam int WR_OPT_N = (MAX_OPTIONS < IN_OPT_N) ? MAX_OPTIONS : IN_OPT_N;

    logic [CFG_W-1:0]  r_entries_in_use;
    logic [CNT_W-1:0]  r_issue_idx;
    logic              r_rd_valid;
    logic              r_matched;
    logic [ADDR_W-1:0] r_target;
    logic [PORT_W-1:0] r_src;
    logic [MASK_W-1:0] r_mask;
    t_decision         r_res_dec;
    logic [PORT_W-1:0] r_res_port;
    logic [MASK_W-1:0] r_res_mask;
    logic              r_out_valid;
    t_decision         r_out_dec;
    logic [PORT_W-1:0] r_out_port;
    logic [MASK_W-1:0] r_out_mask;

    logic [PORT_W-1:0] in_opt [IN_OPT_N];
    logic [ROW_W-1:0]  wr_row;
    logic [OCNT_W-1:0] cnt_sat;
    logic              wr_en;
    logic [ROW_W-1:0]  rd_row;
    logic [CNT_W-1:0]  limit;
    logic              row_match;
    logic [OCNT_W-1:0] row_cnt;
    logic              found;
    logic [PORT_W-1:0] pick;
    logic              is_write;

    assign in_opt[0] = i_option_port_0;
    assign in_opt[1] = i_option_port_1;
    assign in_opt[2] = i_option_port_2;
    assign in_opt[3] = i_option_port_3;

    assign is_write = (i_command == CMD_WRITE);

    // Writes beyond the table are acknowledged but change nothing.
    assign wr_en = i_cmd.accept && is_write
                && (9'(i_entry_index) < 9'(TABLE_ENTRIES));

    always_comb begin
        if (4'(i_option_count) > 4'(MAX_OPTIONS)) begin
            cnt_sat = OCNT_W'(MAX_OPTIONS);
        end else begin
            cnt_sat = i_option_count;
        end
        wr_row = '0;
        wr_row[ROW_W-1 -: ADDR_W] = i_target_address;
        wr_row[OPT_W +: OCNT_W]   = cnt_sat;
        for (int j = 0; j < WR_OPT_N; j++) begin
            wr_row[j*PORT_W +: PORT_W] = in_opt[j];
        end
    end

    rrt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (wr_row),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (r_issue_idx[AW-1:0]),
        .o_rd_data (rd_row)
    );

    always_comb begin
        if (32'(r_entries_in_use) >= 32'(TABLE_ENTRIES)) begin
            limit = CNT_W'(TABLE_ENTRIES);
        end else begin
            limit = CNT_W'(r_entries_in_use);
        end
    end

    // Options of the entry just read are tried in order; ports outside the
    // router never count as available.
    always_comb begin
        logic [PORT_W-1:0] opt;
        row_match = (rd_row[ROW_W-1 -: ADDR_W] == r_target);
        row_cnt   = rd_row[OPT_W +: OCNT_W];
        found     = 1'b0;
        pick      = '0;
        for (int j = 0; j < MAX_OPTIONS; j++) begin
            opt = rd_row[j*PORT_W +: PORT_W];
            if (!found && (4'(j) < 4'(row_cnt)) && (6'(opt) < 6'(PORT_COUNT))
                    && r_mask[opt]) begin
                found = 1'b1;
                pick  = opt;
            end
        end
    end

    assign o_status.in_write   = is_write;
    assign o_status.has_more   = (r_issue_idx < limit);
    assign o_status.eval_valid = r_rd_valid;
    assign o_status.eval_grant = r_rd_valid && row_match && found;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
            r_issue_idx      <= '0;
            r_rd_valid       <= 1'b0;
            r_matched        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entries_in_use <= i_cfg_wr_data;
            end
            r_rd_valid <= i_cmd.issue;
            if (i_cmd.accept) begin
                r_issue_idx <= '0;
                r_matched   <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_issue_idx <= CNT_W'(r_issue_idx + 1'b1);
                end
                if (r_rd_valid && row_match) begin
                    r_matched <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_target <= i_target_address;
            r_src    <= i_source_port;
            r_mask   <= i_available_mask;
            if (is_write) begin
                r_res_dec  <= DEC_WRITTEN;
                r_res_port <= '0;
                r_res_mask <= '0;
            end
        end
        if (i_cmd.finish) begin
            if (o_status.eval_grant) begin
                r_res_dec  <= DEC_GRANT;
                r_res_port <= pick;
                r_res_mask <= MASK_W'(1) << r_src;
            end else begin
                r_res_dec  <= r_matched ? DEC_WAIT : DEC_DISCARD;
                r_res_port <= '0;
                r_res_mask <= '0;
            end
        end
        if (i_cmd.push) begin
            r_out_dec  <= r_res_dec;
            r_out_port <= r_res_port;
            r_out_mask <= r_res_mask;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_decision       = r_out_dec;
    assign o_granted_port   = r_out_port;
    assign o_requester_mask = r_out_mask;
endmodule

// ===== rtl/core/router_route_table_lookup.sv =====
// Top level of the route table lookup block.
//
// Words arrive on i_req with valid/ready. A write word (command 0) loads one
// table entry: target address, option count and up to four candidate ports.
// A route word (command 1) looks up its target address across the first
// entries_in_use entries and answers on o_rsp with grant (port and one-hot
// requester mask), wait (matched, every option busy) or discard (no match).
// Every word yields exactly one response word; a write answers "written".
// entries_in_use is loaded through i_cfg_wr_en / i_cfg_wr_data; the user must
// load it only while idle, which the block itself does not enforce. One word is
// processed at a time. A write has its response loaded without a scan; a route
// walks the table one entry per cycle through the RAM read port and stops early
// on a grant. The next word is taken no sooner than the cycle after the response
// has been loaded into the output register.
// The response sits in an output register; a new word is taken while it
// waits, but a finished result is held back until the receiver frees it.
// Reset (synchronous, active low) clears entries_in_use and all handshake
// state; the table contents are undefined until written.
module router_route_table_lookup #(
    parameter int TABLE_ENTRIES = rrt_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_OPTIONS   = rrt_pkg::DEF_MAX_OPTIONS,
    parameter int PORT_COUNT    = rrt_pkg::DEF_PORT_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rrt_req_if.sink                   i_req,
    rrt_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [rrt_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import rrt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    rrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_OPTIONS   (MAX_OPTIONS),
        .PORT_COUNT    (PORT_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_command        (i_req.command),
        .i_entry_index    (i_req.entry_index),
        .i_target_address (i_req.target_address),
        .i_option_count   (i_req.option_count),
        .i_option_port_0  (i_req.option_port_0),
        .i_option_port_1  (i_req.option_port_1),
        .i_option_port_2  (i_req.option_port_2),
        .i_option_port_3  (i_req.option_port_3),
        .i_source_port    (i_req.source_port),
        .i_available_mask (i_req.available_mask),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_decision       (o_rsp.decision),
        .o_granted_port   (o_rsp.granted_port),
        .o_requester_mask (o_rsp.requester_mask)
    );
endmodule

// ===== tb/tb_router_route_table_lookup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the route table lookup block: directed rows, then random words.
module tb_router_route_table_lookup;
    import rrt_pkg::*;

    localparam int N_ENTRIES   = DEF_TABLE_ENTRIES;
    localparam int N_OPTS      = DEF_MAX_OPTIONS;
    localparam int N_PHASES    = 10;
    localparam int PHASE_WORDS = 158;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_WAIT   = N_ENTRIES + 16;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] target_address;
        logic [OCNT_W-1:0] option_count;
        logic [PORT_W-1:0] port0;
        logic [PORT_W-1:0] port1;
        logic [PORT_W-1:0] port2;
        logic [PORT_W-1:0] port3;
        logic [PORT_W-1:0] source_port;
        logic [MASK_W-1:0] available_mask;
    } rt_word_t;

    typedef struct packed {
        t_decision         decision;
        logic [PORT_W-1:0] granted_port;
        logic [MASK_W-1:0] requester_mask;
    } rt_answer_t;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_kind_e;

    typedef struct {
        row_kind_e        kind;
        logic [CFG_W-1:0] scan_setting;
        rt_word_t         word;
        bit               typed;
        rt_answer_t       answer;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             rx_ready = 1'b0;
    bit               gaps_on = 1'b1;
    int unsigned      hold_req = 0;
    int unsigned      hold_ack = 0;
    int unsigned      hold_left = 0;
    int unsigned      stall_left = 0;
    int unsigned      cycle_count = 0;
    int unsigned      mismatch_count = 0;
    rt_answer_t       want;

    rt_answer_t pending_answers[$];
    stim_row_t  stim_rows[$];

    // Shadow copy of the routing table and of the scan setting.
    logic [ADDR_W-1:0] tbl_addr [N_ENTRIES];
    logic [OCNT_W-1:0] tbl_cnt [N_ENTRIES];
    logic [PORT_W-1:0] tbl_port [N_ENTRIES][N_OPTS];
    logic [CFG_W-1:0]  scan_setting = '0;
    logic [ADDR_W-1:0] addr_pool [8];

    rrt_req_if req_ch ();
    rrt_rsp_if rsp_ch ();

    assign rsp_ch.ready = rx_ready;

    router_route_table_lookup u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch.sink),
        .o_rsp         (rsp_ch.source),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Computes the answer to one word and applies a table write to the shadow copy.
    function automatic rt_answer_t resolve_word(input rt_word_t w);
        rt_answer_t r;
        int         limit;
        bit         hit;
        r = '0;
        r.decision = DEC_WRITTEN;
        if (w.command == CMD_WRITE) begin
            tbl_addr[w.entry_index] = w.target_address;
            tbl_cnt[w.entry_index] = (w.option_count > OCNT_W'(N_OPTS)) ?
                                     OCNT_W'(N_OPTS) : w.option_count;
            tbl_port[w.entry_index][0] = w.port0;
            tbl_port[w.entry_index][1] = w.port1;
            tbl_port[w.entry_index][2] = w.port2;
            tbl_port[w.entry_index][3] = w.port3;
            return r;
        end
        limit = (scan_setting > N_ENTRIES) ? N_ENTRIES : int'(scan_setting);
        hit = 1'b0;
        for (int e = 0; e < limit; e++) begin
            if (tbl_addr[e] == w.target_address) begin
                hit = 1'b1;
                for (int j = 0; j < int'(tbl_cnt[e]); j++) begin
                    if (w.available_mask[tbl_port[e][j]]) begin
                        r.decision = DEC_GRANT;
                        r.granted_port = tbl_port[e][j];
                        r.requester_mask = MASK_W'(1) << w.source_port;
                        return r;
                    end
                end
            end
        end
        r.decision = hit ? DEC_WAIT : DEC_DISCARD;
        return r;
    endfunction

    function automatic stim_row_t write_row(input int idx, input int addr, input int cnt,
                                            input int p0, input int p1, input int p2,
                                            input int p3);
        stim_row_t r;
        r.kind = ROW_WORD;
        r.scan_setting = '0;
        r.word = '0;
        r.word.command = CMD_WRITE;
        r.word.entry_index = IDX_W'(idx);
        r.word.target_address = ADDR_W'(addr);
        r.word.option_count = OCNT_W'(cnt);
        r.word.port0 = PORT_W'(p0);
        r.word.port1 = PORT_W'(p1);
        r.word.port2 = PORT_W'(p2);
        r.word.port3 = PORT_W'(p3);
        r.typed = 1'b1;
        r.answer = '0;
        r.answer.decision = DEC_WRITTEN;
        return r;
    endfunction

    function automatic stim_row_t route_row(input int addr, input int src,
                                            input logic [MASK_W-1:0] mask);
        stim_row_t r;
        r.kind = ROW_WORD;
        r.scan_setting = '0;
        r.word = '0;
        r.word.command = CMD_ROUTE;
        r.word.target_address = ADDR_W'(addr);
        r.word.source_port = PORT_W'(src);
        r.word.available_mask = mask;
        r.typed = 1'b0;
        r.answer = '0;
        return r;
    endfunction

    function automatic stim_row_t answered(input stim_row_t r, input t_decision d,
                                           input int port, input logic [MASK_W-1:0] rmask);
        r.typed = 1'b1;
        r.answer.decision = d;
        r.answer.granted_port = PORT_W'(port);
        r.answer.requester_mask = rmask;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input int n);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.scan_setting = CFG_W'(n);
        r.word = '0;
        r.typed = 1'b0;
        r.answer = '0;
        return r;
    endfunction

    // Mostly addresses from a small pool, so that lookups hit stored entries.
    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 9) == 0) begin
            return ADDR_W'($urandom());
        end
        return addr_pool[$urandom_range(0, 7)];
    endfunction

    function automatic rt_word_t random_write(input int idx);
        rt_word_t w;
        w.command = CMD_WRITE;
        w.entry_index = IDX_W'(idx);
        w.target_address = pick_addr();
        w.option_count = OCNT_W'($urandom_range(0, 7));
        w.port0 = PORT_W'($urandom());
        w.port1 = PORT_W'($urandom());
        w.port2 = PORT_W'($urandom());
        w.port3 = PORT_W'($urandom());
        w.source_port = PORT_W'($urandom());
        w.available_mask = $urandom();
        return w;
    endfunction

    function automatic rt_word_t random_word();
        rt_word_t w;
        w = random_write($urandom_range(0, N_ENTRIES - 1));
        if ($urandom_range(0, 4) == 0) begin
            return w;
        end
        w.command = CMD_ROUTE;
        case ($urandom_range(0, 4))
            0: w.available_mask = $urandom();
            1: w.available_mask = $urandom() & $urandom() & $urandom();
            2: w.available_mask = '1;
            3: w.available_mask = '0;
            default: w.available_mask = MASK_W'(1) << $urandom_range(0, 31);
        endcase
        return w;
    endfunction

    // Offers one word and records its answer once the block has taken it.
    task automatic offer(input rt_word_t w, input bit typed, input rt_answer_t given);
        rt_answer_t predicted;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= w.command;
        req_ch.entry_index <= w.entry_index;
        req_ch.target_address <= w.target_address;
        req_ch.option_count <= w.option_count;
        req_ch.option_port_0 <= w.port0;
        req_ch.option_port_1 <= w.port1;
        req_ch.option_port_2 <= w.port2;
        req_ch.option_port_3 <= w.port3;
        req_ch.source_port <= w.source_port;
        req_ch.available_mask <= w.available_mask;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predicted = resolve_word(w);
        pending_answers.push_back(typed ? given : predicted);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_scan(input logic [CFG_W-1:0] n);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        scan_setting = n;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rx_ready) begin
                if (pending_answers.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: response word with nothing expected: decision %0d port %0d mask %h",
                             $time, rsp_ch.decision, rsp_ch.granted_port, rsp_ch.requester_mask);
                end else begin
                    want = pending_answers.pop_front();
                    if (rsp_ch.decision !== want.decision) begin
                        mismatch_count++;
                        $display("%0t: decision expected %0d, actual %0d",
                                 $time, want.decision, rsp_ch.decision);
                    end
                    if (rsp_ch.granted_port !== want.granted_port) begin
                        mismatch_count++;
                        $display("%0t: granted_port expected %0d, actual %0d",
                                 $time, want.granted_port, rsp_ch.granted_port);
                    end
                    if (rsp_ch.requester_mask !== want.requester_mask) begin
                        mismatch_count++;
                        $display("%0t: requester_mask expected %h, actual %h",
                                 $time, want.requester_mask, rsp_ch.requester_mask);
                    end
                end
            end
            // A long hold-off lets the block fill up and push back on its input.
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rx_ready <= 1'b0;
            end else if (hold_ack != hold_req) begin
                hold_ack <= hold_req;
                hold_left <= LONG_HOLD - 1;
                rx_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                rx_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 16);
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    initial begin
        rt_answer_t no_answer;
        int         phase_scan [N_PHASES];
        no_answer = '0;
        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_WRITE;
        req_ch.entry_index <= '0;
        req_ch.target_address <= '0;
        req_ch.option_count <= '0;
        req_ch.option_port_0 <= '0;
        req_ch.option_port_1 <= '0;
        req_ch.option_port_2 <= '0;
        req_ch.option_port_3 <= '0;
        req_ch.source_port <= '0;
        req_ch.available_mask <= '0;

        // Straight after reset nothing is scanned, so every lookup is discarded.
        stim_rows.push_back(answered(route_row(8'h00, 0, '1), DEC_DISCARD, 0, '0));
        stim_rows.push_back(write_row(0, 8'h00, 2, 31, 0, 0, 0));
        stim_rows.push_back(write_row(1, 8'hFF, 7, 1, 2, 3, 31));
        stim_rows.push_back(write_row(2, 8'h00, 0, 0, 0, 0, 0));
        stim_rows.push_back(write_row(3, 8'hA5, 4, 5, 6, 7, 8));
        stim_rows.push_back(write_row(63, 8'h5A, 1, 17, 31, 31, 31));
        stim_rows.push_back(cfg_row(4));
        stim_rows.push_back(answered(route_row(8'h00, 0, '1), DEC_GRANT, 31, 32'h1));
        stim_rows.push_back(answered(route_row(8'h00, 31, 32'h7FFF_FFFF), DEC_GRANT, 0,
                                     32'h8000_0000));
        // Two entries match, one with no options at all: the lookup waits.
        stim_rows.push_back(answered(route_row(8'h00, 5, '0), DEC_WAIT, 0, '0));
        // An option count above the limit is cut down, so the fourth option still counts.
        stim_rows.push_back(answered(route_row(8'hFF, 3, 32'h8000_0000), DEC_GRANT, 31,
                                     32'h8));
        stim_rows.push_back(route_row(8'hFF, 12, 32'h0000_000C));
        stim_rows.push_back(answered(route_row(8'hA5, 7, 32'hFFFF_FE1F), DEC_WAIT, 0, '0));
        stim_rows.push_back(route_row(8'hA5, 17, 32'h0000_0100));
        stim_rows.push_back(answered(route_row(8'h12, 1, '1), DEC_DISCARD, 0, '0));
        stim_rows.push_back(answered(route_row(8'h5A, 2, '1), DEC_DISCARD, 0, '0));
        stim_rows.push_back(cfg_row(1));
        stim_rows.push_back(answered(route_row(8'hFF, 0, '1), DEC_DISCARD, 0, '0));
        stim_rows.push_back(route_row(8'h00, 9, '1));
        stim_rows.push_back(cfg_row(0));
        stim_rows.push_back(answered(route_row(8'h00, 31, '1), DEC_DISCARD, 0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                settle();
                program_scan(stim_rows[i].scan_setting);
            end else begin
                offer(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].answer);
            end
        end

        foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom());
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        // Every entry is loaded before any lookup can reach it.
        settle();
        program_scan('0);
        for (int e = 0; e < N_ENTRIES; e++) begin
            offer(random_write(e), 1'b0, no_answer);
        end

        phase_scan = '{64, 127, 8, 1, $urandom_range(2, 63), 0, 33, 100,
                       $urandom_range(1, 64), 127};
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            program_scan(CFG_W'(phase_scan[p]));
            if (p == 1) begin
                hold_req <= hold_req + 1;
            end
            if (p == N_PHASES - 1) begin
                gaps_on = 1'b0;
            end
            repeat (PHASE_WORDS) offer(random_word(), 1'b0, no_answer);
        end

        settle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
